// ===== rtl/uwt_pkg.sv =====
// ----------------------------------------------------------------------------
// uwt_pkg
// Shared types and constants for the card identifier whitelist table.
// ----------------------------------------------------------------------------
package uwt_pkg;

  localparam int unsigned SLOT_COUNT_DEFAULT = 31;
  localparam int unsigned QUEUE_DEPTH        = 2;

  localparam logic [31:0] EMPTY_WORD = 32'hFFFF_FFFF;
  localparam logic [4:0]  NO_SLOT    = 5'd31;

  // Function codes on the input channel
  localparam logic [2:0] FUNC_LOOKUP       = 3'd0;
  localparam logic [2:0] FUNC_ENROLL       = 3'd1;
  localparam logic [2:0] FUNC_SET_MASTER   = 3'd2;
  localparam logic [2:0] FUNC_ERASE_ALL    = 3'd3;
  localparam logic [2:0] FUNC_ERASE_MASTER = 3'd4;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_NOT_FOUND = 2'd1,
    STATUS_REJECTED  = 2'd2,
    STATUS_FULL      = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    OP_LOOKUP,
    OP_ENROLL,
    OP_SET_MASTER,
    OP_ERASE_ALL,
    OP_ERASE_MASTER,
    OP_NONE
  } op_e;

  typedef struct packed {
    logic [2:0]  func;
    logic [31:0] uid;
  } in_item_t;

  typedef struct packed {
    logic       found;
    logic [4:0] slot;
    logic [1:0] status;
    logic       master_present;
    logic       programming;
  } out_item_t;

  typedef struct packed {
    op_e         op;
    logic [31:0] uid;
  } job_t;

endpackage

// ===== rtl/uwt_front.sv =====
// ----------------------------------------------------------------------------
// uwt_front
// Input side: takes transactions and decodes the function code into a job.
// ----------------------------------------------------------------------------
module uwt_front (
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  uwt_pkg::in_item_t in_data_i,
  input  logic              q_full_i,
  output logic              push_o,
  output uwt_pkg::job_t     job_o
);
  import uwt_pkg::*;

  op_e op;

  always_comb begin
    case (in_data_i.func)
      FUNC_LOOKUP:       op = OP_LOOKUP;
      FUNC_ENROLL:       op = OP_ENROLL;
      FUNC_SET_MASTER:   op = OP_SET_MASTER;
      FUNC_ERASE_ALL:    op = OP_ERASE_ALL;
      FUNC_ERASE_MASTER: op = OP_ERASE_MASTER;
      default:           op = OP_NONE;
    endcase
  end

  assign in_stall_o = q_full_i;
  assign push_o     = in_valid_i & ~q_full_i;
  assign job_o      = '{op: op, uid: in_data_i.uid};

endmodule

// ===== rtl/uwt_queue.sv =====
// ----------------------------------------------------------------------------
// uwt_queue
// Short job queue between the decoder and the table engine.
// ----------------------------------------------------------------------------
module uwt_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  uwt_pkg::job_t push_data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output uwt_pkg::job_t pop_data_o
);
  import uwt_pkg::*;

  localparam int unsigned PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(QUEUE_DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(QUEUE_DEPTH);

  job_t            entry_q [QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  assign full_o     = (count_q == FullCnt);
  assign valid_o    = (count_q != '0);
  assign pop_data_o = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== rtl/uwt_back.sv =====
// ----------------------------------------------------------------------------
// uwt_back
// Table engine: slot memory, master and programming flags, sequential slot
// scan for lookup and enroll, and the output register.
// ----------------------------------------------------------------------------
module uwt_back #(
  parameter int unsigned SLOT_COUNT = uwt_pkg::SLOT_COUNT_DEFAULT
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_valid_i,
  input  uwt_pkg::job_t      q_data_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output uwt_pkg::out_item_t out_data_o
);
  import uwt_pkg::*;

  localparam int unsigned IdxW = $clog2(SLOT_COUNT);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(SLOT_COUNT - 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0]      state_q, state_d;
  job_t            job_q;
  logic            master_q, master_d;
  logic            prog_q, prog_d;
  out_item_t       res_q, res_d;
  out_item_t       out_q;
  logic            out_valid_q;

  logic [31:0]     mem_q [SLOT_COUNT];
  logic [SLOT_COUNT-1:0] vld_q;
  logic [31:0]     rd_data_q;
  logic            rd_vld_q;

  logic [IdxW-1:0] rd_addr_q;
  logic            issue_q;
  logic            cmp_live_q;
  logic [IdxW-1:0] cmp_idx_q;
  logic            cmp_last_q;

  logic            start_scan;
  logic [IdxW-1:0] start_addr;
  logic            mem_we;
  logic [IdxW-1:0] mem_wa;
  logic [31:0]     mem_wd;
  logic            clr_all;
  logic            clr_master;
  logic            out_free;
  logic [31:0]     word;
  logic            hit;
  logic            scan_step;
  logic            finish_hit;
  logic            finish_miss;

  assign out_free = ~out_valid_q | ~out_stall_i;

  // slots never written since the last erase read as empty
  assign word        = rd_vld_q ? rd_data_q : EMPTY_WORD;
  assign hit         = (job_q.op == OP_LOOKUP) ? (word == job_q.uid) : (word == EMPTY_WORD);
  assign scan_step   = (state_q == S_SCAN) & cmp_live_q;
  assign finish_hit  = scan_step & hit;
  assign finish_miss = scan_step & ~hit & cmp_last_q;

  always_comb begin
    state_d    = state_q;
    master_d   = master_q;
    prog_d     = prog_q;
    res_d      = res_q;
    pop_o      = 1'b0;
    start_scan = 1'b0;
    start_addr = '0;
    mem_we     = 1'b0;
    mem_wa     = '0;
    mem_wd     = job_q.uid;
    clr_all    = 1'b0;
    clr_master = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (q_valid_i) begin
          pop_o   = 1'b1;
          state_d = S_DONE;
          case (q_data_i.op)
            OP_LOOKUP: begin
              start_scan = 1'b1;
              state_d    = S_SCAN;
            end
            OP_ENROLL: begin
              if (prog_q) begin
                start_scan = 1'b1;
                start_addr = IdxW'(1);
                state_d    = S_SCAN;
              end else begin
                res_d = '{found: 1'b0, slot: NO_SLOT, status: STATUS_REJECTED,
                          master_present: master_q, programming: prog_q};
              end
            end
            OP_SET_MASTER: begin
              mem_we   = 1'b1;
              mem_wd   = q_data_i.uid;
              master_d = 1'b1;
              prog_d   = 1'b0;
              res_d    = '{found: 1'b0, slot: 5'd0, status: STATUS_OK,
                           master_present: 1'b1, programming: 1'b0};
            end
            OP_ERASE_ALL: begin
              clr_all  = 1'b1;
              master_d = 1'b0;
              prog_d   = 1'b1;
              res_d    = '{found: 1'b0, slot: NO_SLOT, status: STATUS_OK,
                           master_present: 1'b0, programming: 1'b1};
            end
            OP_ERASE_MASTER: begin
              clr_master = 1'b1;
              master_d   = 1'b0;
              prog_d     = 1'b1;
              res_d      = '{found: 1'b0, slot: 5'd0, status: STATUS_OK,
                             master_present: 1'b0, programming: 1'b1};
            end
            default: begin
              res_d = '{found: 1'b0, slot: NO_SLOT, status: STATUS_OK,
                        master_present: master_q, programming: prog_q};
            end
          endcase
        end
      end
      S_SCAN: begin
        if (finish_hit) begin
          state_d = S_DONE;
          if (job_q.op == OP_LOOKUP) begin
            res_d = '{found: 1'b1, slot: 5'(cmp_idx_q), status: STATUS_OK,
                      master_present: master_q, programming: prog_q};
          end else begin
            mem_we = 1'b1;
            mem_wa = cmp_idx_q;
            res_d  = '{found: 1'b0, slot: 5'(cmp_idx_q), status: STATUS_OK,
                       master_present: master_q, programming: prog_q};
          end
        end else if (finish_miss) begin
          state_d = S_DONE;
          res_d   = '{found: 1'b0, slot: NO_SLOT,
                      status: (job_q.op == OP_LOOKUP) ? STATUS_NOT_FOUND : STATUS_FULL,
                      master_present: master_q, programming: prog_q};
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      master_q    <= 1'b0;
      prog_q      <= 1'b0;
      vld_q       <= '0;
      rd_vld_q    <= 1'b0;
      issue_q     <= 1'b0;
      cmp_live_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      master_q <= master_d;
      prog_q   <= prog_d;
      if (clr_all) begin
        vld_q <= '0;
      end else if (clr_master) begin
        vld_q[0] <= 1'b0;
      end else if (mem_we) begin
        vld_q[mem_wa] <= 1'b1;
      end
      rd_vld_q <= vld_q[rd_addr_q];
      // one read issued per cycle; its compare uses the registered read data
      if (start_scan) begin
        issue_q <= 1'b1;
      end else if ((state_q == S_SCAN) && issue_q && (rd_addr_q == LastIdx)) begin
        issue_q <= 1'b0;
      end
      cmp_live_q <= (state_q == S_SCAN) & issue_q & ~finish_hit & ~finish_miss;
      if ((state_q == S_DONE) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_scan) begin
      rd_addr_q <= start_addr;
    end else if ((state_q == S_SCAN) && issue_q && (rd_addr_q != LastIdx)) begin
      rd_addr_q <= rd_addr_q + IdxW'(1);
    end
    cmp_idx_q  <= rd_addr_q;
    cmp_last_q <= (rd_addr_q == LastIdx);
    rd_data_q  <= mem_q[rd_addr_q];
    if (mem_we) begin
      mem_q[mem_wa] <= mem_wd;
    end
    if (pop_o) begin
      job_q <= q_data_i;
    end
    res_q <= res_d;
    if ((state_q == S_DONE) && out_free) begin
      out_q <= res_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== rtl/uid_whitelist_table.sv =====
// ----------------------------------------------------------------------------
// uid_whitelist_table
// Whitelist of 32-bit card identifiers with a master slot and enrolment.
// ----------------------------------------------------------------------------
// Each transaction on the input channel carries a function code and a card
// identifier and yields exactly one result transaction, in order. Slot 0
// holds the master identifier; slots holding all ones are empty, and every
// slot is empty after reset (per-slot valid bits, no clearing pass). Lookup
// and enroll scan the slot memory one slot per cycle through its single read
// port and stop early when a match comes; set master, erase all, erase master
// and unused codes need no scan. A two-entry job queue lets new transactions
// be taken while a scan runs or a result waits to be collected.
module uid_whitelist_table #(
  parameter int unsigned SLOT_COUNT = uwt_pkg::SLOT_COUNT_DEFAULT
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  uwt_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output uwt_pkg::out_item_t out_data_o
);
  import uwt_pkg::*;

  logic q_full;
  logic push;
  job_t push_job;
  logic pop;
  logic q_valid;
  job_t q_job;

  uwt_front u_front (
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .q_full_i   (q_full),
    .push_o     (push),
    .job_o      (push_job)
  );

  uwt_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_job),
    .full_o      (q_full),
    .pop_i       (pop),
    .valid_o     (q_valid),
    .pop_data_o  (q_job)
  );

  uwt_back #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_data_i    (q_job),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // a match is always reported as ok
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.found |-> out_data_o.status == STATUS_OK)
    else $error("found result without ok status");

  // rejection only happens outside programming mode, and leaves it off
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status == STATUS_REJECTED) |-> !out_data_o.programming)
    else $error("enrol rejected while in programming mode");

  // a full table is only reported for an enrol in programming mode
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status == STATUS_FULL) |->
      out_data_o.programming && !out_data_o.found && (out_data_o.slot == NO_SLOT))
    else $error("inconsistent table full result");

  // the queue never takes a job while full
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !q_full)
    else $error("push into full job queue");

endmodule

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the card identifier whitelist table.
// ----------------------------------------------------------------------------
// Every accepted request is run through a local model of the slot table,
// master mark and programming flag. The predicted reply is queued, and each
// reply taken from the block is checked against the oldest one, field by
// field. A short directed sequence comes first. Random traffic follows, mostly
// realistic programming sessions with lookups of known cards, plus some
// noise. Both channels are throttled in two phases; a third runs unthrottled.
// ----------------------------------------------------------------------------
module tb_top;
  import uwt_pkg::*;

  localparam int unsigned SLOT_COUNT = SLOT_COUNT_DEFAULT;
  localparam int          ITEM_TOTAL = 1750;
  localparam int          DRAIN_CYCLES = 80;
  localparam logic [2:0]  FUNC_FIRST_SPARE = 3'd5;
  localparam logic [2:0]  FUNC_MID_SPARE   = 3'd6;
  localparam logic [2:0]  FUNC_LAST_SPARE  = 3'd7;

  class whitelist_scoreboard;
    logic [31:0] slot_ids [SLOT_COUNT];
    bit          master_mark;
    bit          prog_mode;
    out_item_t   pending_replies [$];
    int          error_count;

    function new();
      foreach (slot_ids[k]) slot_ids[k] = EMPTY_WORD;
      master_mark = 1'b0;
      prog_mode   = 1'b0;
      error_count = 0;
    endfunction

    function out_item_t predict_reply(in_item_t req);
      out_item_t r;
      bit        done;
      r.found  = 1'b0;
      r.slot   = NO_SLOT;
      r.status = STATUS_OK;
      done     = 1'b0;
      case (req.func)
        FUNC_LOOKUP: begin
          // empty slots take part in the comparison too
          r.status = STATUS_NOT_FOUND;
          for (int k = 0; k < SLOT_COUNT; k++) begin
            if (!done && slot_ids[k] == req.uid) begin
              r.found  = 1'b1;
              r.slot   = 5'(k);
              r.status = STATUS_OK;
              done     = 1'b1;
            end
          end
        end
        FUNC_ENROLL: begin
          if (!prog_mode) begin
            r.status = STATUS_REJECTED;
          end else begin
            r.status = STATUS_FULL;
            for (int k = 1; k < SLOT_COUNT; k++) begin
              if (!done && slot_ids[k] == EMPTY_WORD) begin
                slot_ids[k] = req.uid;
                r.slot      = 5'(k);
                r.status    = STATUS_OK;
                done        = 1'b1;
              end
            end
          end
        end
        FUNC_SET_MASTER: begin
          slot_ids[0] = req.uid;
          master_mark = 1'b1;
          prog_mode   = 1'b0;
          r.slot      = '0;
        end
        FUNC_ERASE_ALL: begin
          foreach (slot_ids[k]) slot_ids[k] = EMPTY_WORD;
          master_mark = 1'b0;
          prog_mode   = 1'b1;
        end
        FUNC_ERASE_MASTER: begin
          slot_ids[0] = EMPTY_WORD;
          master_mark = 1'b0;
          prog_mode   = 1'b1;
          r.slot      = '0;
        end
        default: ;
      endcase
      r.master_present = master_mark;
      r.programming    = prog_mode;
      return r;
    endfunction

    function void report_error(string msg);
      if (error_count < 10) $display("ERROR: %s", msg);
      error_count++;
    endfunction

    function void note_request(in_item_t req);
      pending_replies.push_back(predict_reply(req));
    endfunction

    function void check_reply(out_item_t got);
      out_item_t exp_r;
      if (pending_replies.size() == 0) begin
        report_error($sformatf("unexpected reply found=%0d slot=%0d status=%0d mp=%0d prog=%0d",
                               got.found, got.slot, got.status, got.master_present,
                               got.programming));
        return;
      end
      exp_r = pending_replies.pop_front();
      if (got.found !== exp_r.found || got.slot !== exp_r.slot ||
          got.status !== exp_r.status || got.master_present !== exp_r.master_present ||
          got.programming !== exp_r.programming) begin
        report_error($sformatf({"reply mismatch: exp found=%0d slot=%0d status=%0d mp=%0d ",
                                "prog=%0d, got found=%0d slot=%0d status=%0d mp=%0d prog=%0d"},
                               exp_r.found, exp_r.slot, exp_r.status, exp_r.master_present,
                               exp_r.programming, got.found, got.slot, got.status,
                               got.master_present, got.programming));
      end
    endfunction
  endclass

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  in_item_t  in_data_i   = '0;
  logic      out_stall_i = 1'b0;
  logic      in_stall_o;
  logic      out_valid_o;
  out_item_t out_data_o;

  whitelist_scoreboard wl_sb = new();

  int          sent_count   = 0;
  int          in_idle_pct  = 0;
  int          out_idle_pct = 0;
  logic [31:0] known_ids [$];

  always #1 clk_i = ~clk_i;

  uid_whitelist_table #(
    .SLOT_COUNT (SLOT_COUNT)
  ) DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // reply side: take a transaction, then decide the stall for the next cycle
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) wl_sb.check_reply(out_data_o);
    out_stall_i <= ($urandom_range(99) < out_idle_pct);
  end

  function automatic logic [31:0] random_uid();
    logic [31:0] one_hot;
    one_hot = 32'd1 << $urandom_range(31);
    case ($urandom_range(9))
      0:       return EMPTY_WORD;
      1:       return '0;
      2:       return one_hot;
      3:       return ~one_hot;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] pick_known_uid();
    if (known_ids.size() == 0 || $urandom_range(9) < 3) return random_uid();
    return known_ids[$urandom_range(known_ids.size() - 1)];
  endfunction

  task automatic send_request(input logic [2:0] func, input logic [31:0] uid);
    in_item_t req;
    req.func = func;
    req.uid  = uid;
    if (sent_count < ITEM_TOTAL / 3) begin
      in_idle_pct  = 15;
      out_idle_pct = 67;
    end else if (sent_count < 2 * ITEM_TOTAL / 3) begin
      in_idle_pct  = 67;
      out_idle_pct = 15;
    end else begin
      in_idle_pct  = 0;
      out_idle_pct = 0;
    end
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= req;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    wl_sb.note_request(req);
    sent_count++;
    if (func == FUNC_ENROLL || func == FUNC_SET_MASTER) begin
      known_ids.push_back(uid);
      if (known_ids.size() > 48) void'(known_ids.pop_front());
    end
  endtask

  task automatic enroll_session(input int n_cards);
    for (int i = 0; i < n_cards; i++) begin
      send_request(FUNC_ENROLL, random_uid());
      if ($urandom_range(3) == 0) send_request(FUNC_LOOKUP, pick_known_uid());
    end
  endtask

  initial begin
    int kind;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part
    send_request(FUNC_LOOKUP, 32'h1234_5678);
    send_request(FUNC_LOOKUP, EMPTY_WORD);        // matches empty master slot
    send_request(FUNC_ENROLL, 32'h0000_000A);     // refused, not programming
    send_request(FUNC_SET_MASTER, 32'hDEAD_BEEF);
    send_request(FUNC_LOOKUP, 32'hDEAD_BEEF);
    send_request(FUNC_ENROLL, 32'h0000_000B);
    send_request(FUNC_ERASE_MASTER, 32'h5555_5555);
    send_request(FUNC_LOOKUP, 32'hDEAD_BEEF);
    send_request(FUNC_ENROLL, 32'h0000_0000);
    send_request(FUNC_ENROLL, EMPTY_WORD);        // written, still reads empty
    send_request(FUNC_ENROLL, 32'h0000_0001);
    send_request(FUNC_LOOKUP, 32'h0000_0000);
    send_request(FUNC_LOOKUP, 32'h0000_0001);
    send_request(FUNC_LOOKUP, EMPTY_WORD);
    send_request(FUNC_SET_MASTER, 32'h7FFF_FFFF);
    send_request(FUNC_LOOKUP, 32'h7FFF_FFFF);
    send_request(FUNC_ENROLL, 32'h0000_0005);
    send_request(FUNC_FIRST_SPARE, 32'hAAAA_AAAA);
    send_request(FUNC_MID_SPARE, 32'h5555_5555);
    send_request(FUNC_LAST_SPARE, 32'hFFFF_0000);
    send_request(FUNC_ERASE_ALL, 32'h0000_FFFF);
    send_request(FUNC_LOOKUP, 32'h0000_0001);
    send_request(FUNC_ENROLL, 32'h8000_0000);
    send_request(FUNC_LOOKUP, 32'h8000_0000);
    send_request(FUNC_LOOKUP, 32'h7FFF_FFFF);

    // random sessions
    while (sent_count < ITEM_TOTAL) begin
      kind = $urandom_range(99);
      if (kind < 25) begin
        send_request(FUNC_ERASE_ALL, random_uid());
        enroll_session($urandom_range(36, 1));    // long runs overflow the table
      end else if (kind < 40) begin
        send_request(FUNC_ERASE_MASTER, random_uid());
        enroll_session($urandom_range(8, 1));
      end else if (kind < 55) begin
        send_request(FUNC_SET_MASTER, random_uid());
        repeat ($urandom_range(4)) send_request(FUNC_LOOKUP, pick_known_uid());
      end else if (kind < 80) begin
        repeat ($urandom_range(10, 1)) send_request(FUNC_LOOKUP, pick_known_uid());
      end else if (kind < 90) begin
        repeat ($urandom_range(4, 1)) send_request(FUNC_ENROLL, random_uid());
      end else begin
        repeat ($urandom_range(5, 1))
          send_request(3'($urandom_range(FUNC_LAST_SPARE, FUNC_LOOKUP)), random_uid());
      end
    end
    in_valid_i <= 1'b0;

    while (wl_sb.pending_replies.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (wl_sb.pending_replies.size() != 0)
      wl_sb.report_error("replies still outstanding at end of run");

    if (wl_sb.error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #1000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
